/* src/ptb_pkg.sv */
// shared types and constants for the progress timer bank
// no dependencies
`default_nettype none
package ptb_pkg;

  localparam logic [16:0] ONE_PROG   = 17'd65536;
  localparam logic [31:0] ONE_Q16    = 32'd65536;
  localparam logic [31:0] TENTH_Q16  = 32'd6554;
  localparam int unsigned DIV_STEPS  = 16;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REINIT = 2'd3
  } opcode_e;

  typedef enum logic {
    REG_ANIMS    = 1'b0,
    REG_FAMILIES = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DIV,
    ST_TICK_WR,
    ST_NEXT,
    ST_QRY_RD,
    ST_QRY_RESP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic        idle;
    logic [32:0] elapsed;
    logic [31:0] dur;
    logic [16:0] prog;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{idle: 1'b1, elapsed: '0, dur: '0, prog: '0};

  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_query;
    logic calc;
    logic div_step;
    logic wr_tick;
    logic wr_start;
    logic wr_reinit;
    logic wr_clear;
    logic scan_next;
    logic resp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    cfg_hit;
    logic    clr_last;
    opcode_e op;
    logic    in_range;
    logic    scan_empty;
    logic    scan_last;
    logic    active;
    logic    div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

/* src/ptb_ram.sv */
// generic single-port-write, registered-read memory
// no dependencies
`default_nettype none
module ptb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

/* src/ptb_datapath.sv */
// datapath: config registers, scan counters, timer store, divider, result registers
// depends on ptb_pkg and ptb_ram
`default_nettype none
module ptb_datapath #(
  parameter int unsigned NUM_ANIMS    = 16,
  parameter int unsigned NUM_FAMILIES = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_addr_i,
  input  wire logic [4:0]         cfg_wdata_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [3:0]         anim_index_i,
  input  wire logic [2:0]         family_index_i,
  input  wire logic [31:0]        time_value_i,
  input  wire ptb_pkg::ctrl_cmd_t cmd_i,
  output ptb_pkg::dp_stat_t       stat_o,
  output logic                    done_o,
  output logic                    is_available_o,
  output logic [16:0]             progress_o,
  output logic [31:0]             duration_out_o
);

  localparam int unsigned DEPTH = NUM_ANIMS * NUM_FAMILIES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
  localparam int unsigned CW    = (NUM_FAMILIES > 1) ? $clog2(NUM_FAMILIES) : 1;

  logic [4:0]  anims_q;
  logic [3:0]  fams_q;
  logic [4:0]  rows;
  logic [3:0]  cols;
  logic        cfg_hit;

  ptb_pkg::opcode_e op_q;
  logic [3:0]  aidx_q;
  logic [2:0]  fidx_q;
  logic [31:0] time_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [AW-1:0] clr_q;

  logic [32:0] e_q;
  logic [31:0] dur_q;
  logic        free_q;
  logic [31:0] rem_q;
  logic [15:0] quo_q;
  logic [3:0]  cnt_q;

  logic        done_q;
  logic        avail_q;
  logic [16:0] prog_q;
  logic [31:0] dout_q;

  logic [AW-1:0] saddr, qaddr, addr;
  logic          we, re;
  ptb_pkg::entry_t wdata, rdata;
  logic [32:0] e_new;
  logic [32:0] rem_sh;
  logic        ge;
  logic [16:0] tick_prog;

  assign cfg_hit = cfg_we_i &&
                   (cfg_addr_i == ptb_pkg::REG_ANIMS || cfg_addr_i == ptb_pkg::REG_FAMILIES);
  assign rows = (32'(anims_q) > NUM_ANIMS) ? 5'(NUM_ANIMS) : anims_q;
  assign cols = (32'(fams_q) > NUM_FAMILIES) ? 4'(NUM_FAMILIES) : fams_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anims_q <= '0;
      fams_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == ptb_pkg::REG_ANIMS) begin
        anims_q <= cfg_wdata_i;
      end else begin
        fams_q <= cfg_wdata_i[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cfg_hit) begin
      clr_q <= '0;
    end else if (cmd_i.wr_clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // latched request and scan position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= ptb_pkg::opcode_e'(opcode_i);
      aidx_q <= anim_index_i;
      fidx_q <= family_index_i;
      time_q <= time_value_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cmd_i.scan_next) begin
      if (32'(col_q) + 32'd1 == 32'(cols)) begin
        col_q <= '0;
        row_q <= row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  assign saddr = AW'(32'(row_q) * NUM_FAMILIES + 32'(col_q));
  assign qaddr = AW'(32'(aidx_q) * NUM_FAMILIES + 32'(fidx_q));

  always_comb begin
    if (cmd_i.wr_clear) begin
      addr = clr_q;
    end else if (cmd_i.wr_start || cmd_i.rd_query) begin
      addr = qaddr;
    end else begin
      addr = saddr;
    end
  end

  assign re = cmd_i.rd_scan || cmd_i.rd_query;
  assign we = cmd_i.wr_clear || cmd_i.wr_start || cmd_i.wr_reinit || cmd_i.wr_tick;

  assign tick_prog = (dur_q == '0 || e_q >= {1'b0, dur_q}) ? ptb_pkg::ONE_PROG
                                                          : {1'b0, quo_q};

  always_comb begin
    wdata = ptb_pkg::ENTRY_RESET;
    if (cmd_i.wr_start) begin
      wdata.idle = 1'b0;
      wdata.dur  = (time_q == '0) ? ptb_pkg::ONE_Q16 : time_q;
    end else if (cmd_i.wr_reinit) begin
      wdata     = rdata;
      wdata.dur = ptb_pkg::TENTH_Q16;
    end else if (cmd_i.wr_tick && !free_q) begin
      wdata.idle    = 1'b0;
      wdata.elapsed = e_q;
      wdata.dur     = dur_q;
      wdata.prog    = tick_prog;
    end
  end

  ptb_ram #(
    .WIDTH ($bits(ptb_pkg::entry_t)),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (re),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // elapsed update and restoring divider, one quotient bit a cycle
  // the divider only matters when elapsed is below the duration, so the
  // remainder always fits in 32 bits
  assign e_new  = rdata.elapsed + 33'(time_q);
  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, dur_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      e_q    <= e_new;
      dur_q  <= rdata.dur;
      free_q <= ({1'b0, e_new} + 34'(time_q)) > 34'(rdata.dur);
      rem_q  <= e_new[31:0];
      quo_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(rem_sh - {1'b0, dur_q}) : rem_sh[31:0];
      quo_q <= {quo_q[14:0], ge};
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // result registers, zero outside the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      avail_q <= 1'b0;
      prog_q  <= '0;
      dout_q  <= '0;
    end else begin
      done_q  <= cmd_i.resp;
      avail_q <= 1'b0;
      prog_q  <= '0;
      dout_q  <= '0;
      if (cmd_i.resp && op_q == ptb_pkg::OP_QUERY) begin
        if (stat_o.in_range) begin
          avail_q <= rdata.idle;
          prog_q  <= rdata.prog;
          dout_q  <= rdata.dur;
        end else begin
          prog_q <= ptb_pkg::ONE_PROG;
          dout_q <= ptb_pkg::ONE_Q16;
        end
      end
    end
  end

  assign done_o         = done_q;
  assign is_available_o = avail_q;
  assign progress_o     = prog_q;
  assign duration_out_o = dout_q;

  always_comb begin
    stat_o.cfg_hit    = cfg_hit;
    stat_o.clr_last   = (32'(clr_q) == DEPTH - 1);
    stat_o.op         = op_q;
    stat_o.in_range   = ({1'b0, aidx_q} < rows) && ({1'b0, fidx_q} < cols);
    stat_o.scan_empty = (rows == '0) || (cols == '0);
    stat_o.scan_last  = (32'(row_q) + 32'd1 == 32'(rows)) &&
                        (32'(col_q) + 32'd1 == 32'(cols));
    stat_o.active     = !rdata.idle;
    stat_o.div_last   = (32'(cnt_q) == ptb_pkg::DIV_STEPS - 1);
  end

endmodule
`default_nettype wire

/* src/ptb_ctrl.sv */
// controller state machine for the progress timer bank
// depends on ptb_pkg
`default_nettype none
module ptb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire ptb_pkg::dp_stat_t stat_i,
  output ptb_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy_o
);

  ptb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptb_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptb_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ptb_pkg::ST_IDLE;
      end
      ptb_pkg::ST_IDLE: begin
        if (start_i) state_d = ptb_pkg::ST_DISPATCH;
      end
      ptb_pkg::ST_DISPATCH: begin
        unique case (stat_i.op)
          ptb_pkg::OP_START: state_d = ptb_pkg::ST_RESP;
          ptb_pkg::OP_QUERY:
            state_d = stat_i.in_range ? ptb_pkg::ST_QRY_RD : ptb_pkg::ST_RESP;
          default:
            state_d = stat_i.scan_empty ? ptb_pkg::ST_RESP : ptb_pkg::ST_SCAN_RD;
        endcase
      end
      ptb_pkg::ST_SCAN_RD:  state_d = ptb_pkg::ST_SCAN_CHK;
      ptb_pkg::ST_SCAN_CHK: begin
        if (stat_i.op == ptb_pkg::OP_TICK && stat_i.active) begin
          state_d = ptb_pkg::ST_DIV;
        end else begin
          state_d = ptb_pkg::ST_NEXT;
        end
      end
      ptb_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = ptb_pkg::ST_TICK_WR;
      end
      ptb_pkg::ST_TICK_WR:  state_d = ptb_pkg::ST_NEXT;
      ptb_pkg::ST_NEXT: begin
        state_d = stat_i.scan_last ? ptb_pkg::ST_RESP : ptb_pkg::ST_SCAN_RD;
      end
      ptb_pkg::ST_QRY_RD:   state_d = ptb_pkg::ST_QRY_RESP;
      ptb_pkg::ST_QRY_RESP: state_d = ptb_pkg::ST_IDLE;
      ptb_pkg::ST_RESP:     state_d = ptb_pkg::ST_IDLE;
      default:              state_d = ptb_pkg::ST_CLEAR;
    endcase
    if (stat_i.cfg_hit) state_d = ptb_pkg::ST_CLEAR;
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ptb_pkg::ST_CLEAR:    cmd_o.wr_clear = 1'b1;
      ptb_pkg::ST_IDLE:     cmd_o.load = start_i && !stat_i.cfg_hit;
      ptb_pkg::ST_DISPATCH: cmd_o.wr_start = (stat_i.op == ptb_pkg::OP_START) &&
                                             stat_i.in_range;
      ptb_pkg::ST_SCAN_RD:  cmd_o.rd_scan = 1'b1;
      ptb_pkg::ST_SCAN_CHK: begin
        cmd_o.wr_reinit = (stat_i.op == ptb_pkg::OP_REINIT);
        cmd_o.calc      = (stat_i.op == ptb_pkg::OP_TICK) && stat_i.active;
      end
      ptb_pkg::ST_DIV:      cmd_o.div_step = 1'b1;
      ptb_pkg::ST_TICK_WR:  cmd_o.wr_tick = 1'b1;
      ptb_pkg::ST_NEXT:     cmd_o.scan_next = !stat_i.scan_last;
      ptb_pkg::ST_QRY_RD:   cmd_o.rd_query = 1'b1;
      ptb_pkg::ST_QRY_RESP: cmd_o.resp = 1'b1;
      ptb_pkg::ST_RESP:     cmd_o.resp = 1'b1;
      default:              cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ptb_pkg::ST_IDLE);

endmodule
`default_nettype wire

/* src/progress_timer_bank_top.sv */
// top level of the progress timer bank
// depends on ptb_pkg, ptb_ctrl, ptb_datapath (and ptb_ram below it)
//
// usage
//   command channel: a command is taken at a rising edge with start_i high and busy_o low
//   (opcode_i: tick, start, query, reinit; anim_index_i, family_index_i, time_value_i)
//   result channel: exactly one result per command, shown for one cycle with done_o high;
//   the receiver cannot stall, so the transfer completes at the end of that cycle
//   outside the strobe the result ports read zero
//   config port: cfg_we_i, cfg_addr_i (0 rows in use, 1 columns in use), cfg_wdata_i;
//   a write restarts the clearing pass, write only while busy_o is low
// processing, one command at a time
//   start: DISPATCH, writing the entry when in range, then RESP; query in range: DISPATCH,
//   QRY_RD, QRY_RESP, else RESP; RESP and QRY_RESP set the registered done_o strobe
//   tick and reinit walk every entry in use through the single store port (SCAN_RD,
//   SCAN_CHK, NEXT); a running timer under tick adds DIV (bit-serial divider) and TICK_WR
// reset
//   config registers clear to zero, then a clearing pass writes every one of
//   NUM_ANIMS * NUM_FAMILIES entries, one a cycle, with busy_o high
`default_nettype none
module progress_timer_bank_top #(
  parameter int unsigned NUM_ANIMS    = 16,
  parameter int unsigned NUM_FAMILIES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  anim_index_i,
  input  wire logic [2:0]  family_index_i,
  input  wire logic [31:0] time_value_i,
  output logic             done_o,
  output logic             is_available_o,
  output logic [16:0]      progress_o,
  output logic [31:0]      duration_out_o
);

  // command and status between controller and datapath
  ptb_pkg::ctrl_cmd_t cmd;
  ptb_pkg::dp_stat_t  stat;

  ptb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ptb_datapath #(
    .NUM_ANIMS    (NUM_ANIMS),
    .NUM_FAMILIES (NUM_FAMILIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .anim_index_i   (anim_index_i),
    .family_index_i (family_index_i),
    .time_value_i   (time_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .done_o         (done_o),
    .is_available_o (is_available_o),
    .progress_o     (progress_o),
    .duration_out_o (duration_out_o)
  );

endmodule
`default_nettype wire

/* src/ptb_checker.sv */
// port-level checker for the progress timer bank, bound to the top level
// depends on progress_timer_bank_top
`default_nettype none
module ptb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        is_available_o,
  input wire logic [16:0] progress_o,
  input wire logic [31:0] duration_out_o
);

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised after command");

  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without work");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_quiet_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (!is_available_o && progress_o == '0 && duration_out_o == '0))
    else $error("result ports not quiet");

  a_prog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    progress_o <= 17'd65536) else $error("progress above one");

endmodule

bind progress_timer_bank_top ptb_checker u_ptb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .is_available_o (is_available_o),
  .progress_o     (progress_o),
  .duration_out_o (duration_out_o)
);
`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the progress timer bank: directed table, then random commands
// checked against a behavioural predictor of the timer store; depends on ptb_pkg and
// progress_timer_bank_top
`timescale 1ns / 100ps
module tb;

  localparam int unsigned ROWS = 16;
  localparam int unsigned COLS = 8;
  localparam int unsigned NTIMERS = ROWS * COLS;
  localparam int unsigned N_RANDOM = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [3:0]  anim_idx = '0;
  logic [2:0]  fam_idx = '0;
  logic [31:0] time_val = '0;
  logic        done;
  logic        avail;
  logic [16:0] prog;
  logic [31:0] dur_out;

  // one expected query answer
  typedef struct packed {
    logic        avail;
    logic [16:0] prog;
    logic [31:0] dur;
  } answer_t;

  // directed row: command plus an optional typed-in answer
  typedef struct {
    ptb_pkg::opcode_e op;
    logic [3:0]  a;
    logic [2:0]  f;
    logic [31:0] t;
    bit          fixed;
    answer_t     ans;
  } cmd_row_t;

  // predictor copy of the timer store and config
  logic        tmr_idle [NTIMERS];
  logic [32:0] tmr_elapsed [NTIMERS];
  logic [31:0] tmr_dur [NTIMERS];
  logic [16:0] tmr_prog [NTIMERS];
  logic [4:0]  rows_reg;
  logic [3:0]  cols_reg;

  answer_t answers_due[$];
  int      mismatches = 0;
  int      transfers_out = 0;
  int      queries_sent = 0;

  progress_timer_bank_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .start_i(start), .busy_o(busy),
    .opcode_i(opcode), .anim_index_i(anim_idx), .family_index_i(fam_idx),
    .time_value_i(time_val),
    .done_o(done), .is_available_o(avail), .progress_o(prog), .duration_out_o(dur_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generous overall limit: every tick can walk the full store, dividing for each running timer
  initial begin
    #50ms;
    $display("timeout with %0d results still due", answers_due.size());
    $display("status: fail");
    $finish;
  end

  function automatic void clear_timers();
    for (int k = 0; k < NTIMERS; k++) begin
      tmr_idle[k] = 1'b1;
      tmr_elapsed[k] = '0;
      tmr_dur[k] = '0;
      tmr_prog[k] = '0;
    end
  endfunction

  function automatic logic [16:0] progress_ratio(logic [32:0] num, logic [31:0] den);
    logic [63:0] q;
    if (den == 0) return ptb_pkg::ONE_PROG;
    q = {15'd0, num, 16'd0} / {32'd0, den};
    return (q > 64'd65536) ? ptb_pkg::ONE_PROG : q[16:0];
  endfunction

  // advance the predictor by one command and return the answer it yields
  function automatic answer_t timer_bank_step(ptb_pkg::opcode_e op, logic [3:0] a,
                                              logic [2:0] f, logic [31:0] t);
    int unsigned rows, cols, k, j;
    logic [32:0] e;
    answer_t res;
    rows = (rows_reg < ROWS) ? rows_reg : ROWS;
    cols = (cols_reg < COLS) ? cols_reg : COLS;
    k = a * COLS + f;
    res = '0;
    case (op)
      ptb_pkg::OP_TICK: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++) begin
            j = r * COLS + c;
            if (!tmr_idle[j]) begin
              e = tmr_elapsed[j] + {1'b0, t};
              tmr_elapsed[j] = e;
              tmr_prog[j] = progress_ratio(e, tmr_dur[j]);
              // freeing test uses elapsed plus one more delta, wider than 33 bits
              if ({1'b0, e} + {2'b0, t} > {2'b0, tmr_dur[j]}) begin
                tmr_idle[j] = 1'b1;
                tmr_elapsed[j] = '0;
                tmr_dur[j] = '0;
                tmr_prog[j] = '0;
              end
            end
          end
      end
      ptb_pkg::OP_START: begin
        if (a < rows && f < cols) begin
          tmr_idle[k] = 1'b0;
          tmr_elapsed[k] = '0;
          tmr_prog[k] = '0;
          tmr_dur[k] = (t == 0) ? ptb_pkg::ONE_Q16 : t;
        end
      end
      ptb_pkg::OP_QUERY: begin
        if (a < rows && f < cols) res = '{tmr_idle[k], tmr_prog[k], tmr_dur[k]};
        else res = '{1'b0, ptb_pkg::ONE_PROG, ptb_pkg::ONE_Q16};
      end
      default: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++) tmr_dur[r * COLS + c] = ptb_pkg::TENTH_Q16;
      end
    endcase
    return res;
  endfunction

  // result checker: every strobe pops the oldest expectation, or counts a mismatch when none is due
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && done) begin
      transfers_out++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = answers_due.pop_front();
        if (avail !== want.avail || prog !== want.prog || dur_out !== want.dur) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want avail %0d prog %0d dur %0d, got %0d %0d %0d",
                     want.avail, want.prog, want.dur, avail, prog, dur_out);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  // one command transfer; the expectation is queued at the accepting edge
  // the first edge keeps the drop of start apart from the next raise
  task automatic send_cmd(ptb_pkg::opcode_e op, logic [3:0] a, logic [2:0] f,
                          logic [31:0] t, bit fixed, answer_t given, bit gaps);
    answer_t got;
    @(posedge clk);
    if (gaps) idle_gap();
    start <= 1'b1;
    opcode <= op;
    anim_idx <= a;
    fam_idx <= f;
    time_val <= t;
    do @(posedge clk); while (busy);
    got = timer_bank_step(op, a, f, t);
    answers_due.push_back(fixed ? given : got);
    if (op == ptb_pkg::OP_QUERY) queries_sent++;
    start <= 1'b0;
  endtask

  // drain, settle, then write one register; the store clears in the predictor too
  task automatic write_cfg(ptb_pkg::cfg_reg_e idx, logic [4:0] val);
    int guard;
    guard = 0;
    while (answers_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ptb_pkg::REG_ANIMS) rows_reg = val;
    else cols_reg = val[3:0];
    clear_timers();
  endtask

  cmd_row_t directed[$];

  function automatic cmd_row_t row(ptb_pkg::opcode_e op, logic [3:0] a, logic [2:0] f,
                                   logic [31:0] t, bit fixed = 0, answer_t ans = '0);
    cmd_row_t r;
    r.op = op; r.a = a; r.f = f; r.t = t; r.fixed = fixed; r.ans = ans;
    return r;
  endfunction

  initial begin
    ptb_pkg::opcode_e op;
    logic [3:0] a;
    logic [2:0] f;
    logic [31:0] t;
    int pick;
    rows_reg = '0;
    cols_reg = '0;
    clear_timers();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bank disabled after reset: queries report not available with 1.0
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd0, 3'd0, 32'd0, 1,
                           '{1'b0, ptb_pkg::ONE_PROG, ptb_pkg::ONE_Q16}));
    directed.push_back(row(ptb_pkg::OP_START, 4'd0, 3'd0, 32'd100, 1, '0));
    directed.push_back(row(ptb_pkg::OP_TICK, 4'd15, 3'd7, 32'hFFFF_FFFF, 1, '0));
    foreach (directed[i])
      send_cmd(directed[i].op, directed[i].a, directed[i].f, directed[i].t,
               directed[i].fixed, directed[i].ans, 0);

    // full bank, register above the parameter range
    write_cfg(ptb_pkg::REG_ANIMS, 5'd31);
    write_cfg(ptb_pkg::REG_FAMILIES, 4'd15);
    directed.delete();
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd15, 3'd7, 32'd0, 1, '{1'b1, 17'd0, 32'd0}));
    directed.push_back(row(ptb_pkg::OP_START, 4'd0, 3'd0, 32'd0));  // zero duration gives 1.0
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd0, 3'd0, 32'd0, 1,
                           '{1'b0, 17'd0, ptb_pkg::ONE_Q16}));
    directed.push_back(row(ptb_pkg::OP_START, 4'd15, 3'd7, 32'hFFFF_FFFF));
    directed.push_back(row(ptb_pkg::OP_START, 4'd3, 3'd2, 32'h0004_0000));
    directed.push_back(row(ptb_pkg::OP_TICK, 4'd0, 3'd0, 32'h0000_4000));
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd0, 3'd0, 32'd0));
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd3, 3'd2, 32'd0));
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd15, 3'd7, 32'd0));
    directed.push_back(row(ptb_pkg::OP_REINIT, 4'd0, 3'd0, 32'd0));
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd3, 3'd2, 32'd0, 1,
                           '{1'b0, 17'd4096, ptb_pkg::TENTH_Q16}));
    directed.push_back(row(ptb_pkg::OP_TICK, 4'd0, 3'd0, 32'd1000));
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd3, 3'd2, 32'd0));
    // frees every running timer
    directed.push_back(row(ptb_pkg::OP_TICK, 4'd0, 3'd0, 32'hFFFF_FFFF));
    directed.push_back(row(ptb_pkg::OP_QUERY, 4'd15, 3'd7, 32'd0, 1, '{1'b1, 17'd0, 32'd0}));
    foreach (directed[i])
      send_cmd(directed[i].op, directed[i].a, directed[i].f, directed[i].t,
               directed[i].fixed, directed[i].ans, 1);

    // partial bank: indexes past the sizes must be ignored
    write_cfg(ptb_pkg::REG_ANIMS, 5'd2);
    write_cfg(ptb_pkg::REG_FAMILIES, 4'd3);
    send_cmd(ptb_pkg::OP_START, 4'd2, 3'd0, 32'd5, 0, '0, 1);
    send_cmd(ptb_pkg::OP_QUERY, 4'd2, 3'd0, 32'd0, 1,
             '{1'b0, ptb_pkg::ONE_PROG, ptb_pkg::ONE_Q16}, 1);
    send_cmd(ptb_pkg::OP_QUERY, 4'd1, 3'd3, 32'd0, 1,
             '{1'b0, ptb_pkg::ONE_PROG, ptb_pkg::ONE_Q16}, 1);

    // random phases over several sizes, small, full and empty; mostly start/tick/query
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_cfg(ptb_pkg::REG_ANIMS, 5'd3);
          write_cfg(ptb_pkg::REG_FAMILIES, 4'd2);
        end
        1: begin
          write_cfg(ptb_pkg::REG_ANIMS, 5'd1);
          write_cfg(ptb_pkg::REG_FAMILIES, 4'd1);
        end
        2: begin
          write_cfg(ptb_pkg::REG_ANIMS, 5'd16);
          write_cfg(ptb_pkg::REG_FAMILIES, 4'd8);
        end
        default: begin
          write_cfg(ptb_pkg::REG_ANIMS, 5'd4);
          write_cfg(ptb_pkg::REG_FAMILIES, 4'd0);
        end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        pick = $urandom_range(0, 9);
        op = (pick < 3) ? ptb_pkg::OP_START :
             (pick < 6) ? ptb_pkg::OP_QUERY :
             (pick < 9) ? ptb_pkg::OP_TICK : ptb_pkg::OP_REINIT;
        a = (rows_reg != 0 && $urandom_range(0, 4) != 0) ?
            4'($urandom_range(0, (rows_reg > ROWS ? ROWS : rows_reg) - 1)) : 4'($urandom);
        f = (cols_reg != 0 && $urandom_range(0, 4) != 0) ?
            3'($urandom_range(0, (cols_reg > COLS ? COLS : cols_reg) - 1)) : 3'($urandom);
        case ($urandom_range(0, 3))
          0: t = $urandom;
          1: t = $urandom_range(0, 32'h0002_0000);
          2: t = (op == ptb_pkg::OP_TICK) ? $urandom_range(0, 32'h0000_8000)
                                          : $urandom_range(0, 8);
          default: t = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
        send_cmd(op, a, f, t, 0, '0, 1);
      end
    end

    // wait for everything outstanding, then the store-walk latency
    fork
      wait (answers_due.size() == 0);
      begin repeat (200000) @(posedge clk); end
    join_any
    disable fork;
    repeat (2600) @(posedge clk);

    $display("covered %0d results (%0d queries) over several bank sizes, %0d mismatches",
             transfers_out, queries_sent, mismatches);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
